[sv/bpt_pkg.sv]
package bpt_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_OUTCOME = 2'd0;
  localparam logic [1:0] OP_SIGNAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PRIOR_ALPHA   = 2'd0;
  localparam logic [1:0] REG_PRIOR_BETA    = 2'd1;
  localparam logic [1:0] REG_FORGETTING    = 2'd2;
  localparam logic [1:0] REG_LOW_THRESHOLD = 2'd3;

  // Reset values of the configuration registers
  localparam logic [31:0] PRIOR_RESET      = 32'd65536;
  localparam logic [16:0] FORGETTING_RESET = 17'd65536;
  localparam logic [16:0] THRESHOLD_RESET  = 17'd0;

  typedef struct packed {
    logic [1:0] operation;
    logic       direction;
    logic       win;
  } in_item_t;

  typedef struct packed {
    logic [16:0] posterior;
    logic [32:0] precision;
    logic        low_confidence;
    logic [31:0] signal_count;
    logic [31:0] outcome_count;
    logic [31:0] low_event_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DECAY_A,
    S_DECAY_B,
    S_BUMP,
    S_SETUP,
    S_DIVIDE,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic decay_a;
    logic decay_b;
    logic bump;
    logic setup;
    logic div_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic outcome;
    logic needs_decay;
    logic out_free;
  } status_t;

endpackage

[sv/bpt_ctrl.sv]
module bpt_ctrl
  import bpt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  localparam int CNTW = $clog2(FRAC_BITS + 1);

  state_e          state_q, state_d;
  logic [CNTW-1:0] step_q, step_d;

  // State and divide step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_FETCH;
      end
      S_FETCH: begin
        if (status_i.outcome && status_i.needs_decay) state_d = S_DECAY_A;
        else if (status_i.outcome)                    state_d = S_BUMP;
        else                                          state_d = S_SETUP;
      end
      S_DECAY_A: state_d = S_DECAY_B;
      S_DECAY_B: state_d = S_BUMP;
      S_BUMP:    state_d = S_SETUP;
      S_SETUP: begin
        state_d = S_DIVIDE;
        step_d  = CNTW'(FRAC_BITS);
      end
      S_DIVIDE: begin
        if (step_q == '0) state_d = S_FINISH;
        else              step_d  = step_q - 1'b1;
      end
      S_FINISH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:    cmd_o.accept   = in_valid_i;
      S_FETCH:   cmd_o.fetch    = 1'b1;
      S_DECAY_A: cmd_o.decay_a  = 1'b1;
      S_DECAY_B: cmd_o.decay_b  = 1'b1;
      S_BUMP:    cmd_o.bump     = 1'b1;
      S_SETUP:   cmd_o.setup    = 1'b1;
      S_DIVIDE:  cmd_o.div_step = 1'b1;
      S_FINISH:  cmd_o.finish   = status_i.out_free;
      default:   cmd_o          = '0;
    endcase
  end

endmodule

[sv/bpt_datapath.sv]
module bpt_datapath
  import bpt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  // Common width for Q1.FRAC_BITS values and the 17-bit registers
  localparam int CW = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
  localparam int PW = 32 + CW;
  localparam int QW = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE_CW  = CW'(1) << FRAC_BITS;
  localparam logic [32:0]   ONE_33  = 33'd1 << FRAC_BITS;

  // Configuration registers
  logic [31:0] prior_alpha_q, prior_beta_q;
  logic [16:0] forgetting_q, threshold_q;

  // Count stores and event counters
  logic [31:0] alpha_q [2];
  logic [31:0] beta_q  [2];
  logic [31:0] signals_q, outcomes_q, lows_q;

  // Working registers
  in_item_t    item_q;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [32:0] sum_q;
  logic [33:0] rem_q;
  logic [QW-1:0] quo_q;

  // Output register
  logic      out_valid_q;
  out_item_t out_q;

  logic [CW-1:0] forget_ext, thr_ext, post_ext;
  logic [31:0]   mul_in;
  logic [PW-1:0] product;
  logic [31:0]   decayed, bump_in, bumped;
  logic [32:0]   bump_sum;
  logic          ge;
  logic [33:0]   rem_sub;
  logic          low;

  assign forget_ext = CW'(forgetting_q);
  assign thr_ext    = CW'(threshold_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_alpha_q <= PRIOR_RESET;
      prior_beta_q  <= PRIOR_RESET;
      forgetting_q  <= FORGETTING_RESET;
      threshold_q   <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PRIOR_ALPHA:   prior_alpha_q <= cfg_data_i;
        REG_PRIOR_BETA:    prior_beta_q  <= cfg_data_i;
        REG_FORGETTING:    forgetting_q  <= cfg_data_i[16:0];
        REG_LOW_THRESHOLD: threshold_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Decay multiplier, shared by alpha and beta
  assign mul_in  = cmd_i.decay_b ? b_q : a_q;
  assign product = PW'(mul_in) * PW'(forget_ext);
  assign decayed = product[FRAC_BITS +: 32];

  // Saturating increment by 1.0 (1 << FRAC_BITS)
  assign bump_in  = item_q.win ? a_q : b_q;
  assign bump_sum = {1'b0, bump_in} + ONE_33;
  assign bumped   = bump_sum[32] ? 32'hFFFF_FFFF : bump_sum[31:0];

  // Working count next values
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    if (cmd_i.fetch) begin
      if (item_q.operation == OP_CLEAR) begin
        a_d = prior_alpha_q;
        b_d = prior_beta_q;
      end else begin
        a_d = alpha_q[item_q.direction];
        b_d = beta_q[item_q.direction];
      end
    end else if (cmd_i.decay_a) begin
      a_d = decayed;
    end else if (cmd_i.decay_b) begin
      b_d = decayed;
    end else if (cmd_i.bump) begin
      if (item_q.win) a_d = bumped;
      else            b_d = bumped;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_item_i;
    a_q <= a_d;
    b_q <= b_d;
  end

  // Stores and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q[0] <= PRIOR_RESET;
      alpha_q[1] <= PRIOR_RESET;
      beta_q[0]  <= PRIOR_RESET;
      beta_q[1]  <= PRIOR_RESET;
      signals_q  <= '0;
      outcomes_q <= '0;
      lows_q     <= '0;
    end else begin
      if (cmd_i.fetch) begin
        if (item_q.operation == OP_OUTCOME) outcomes_q <= outcomes_q + 1'b1;
        if (item_q.operation == OP_SIGNAL)  signals_q  <= signals_q + 1'b1;
        if (item_q.operation == OP_CLEAR) begin
          alpha_q[0] <= prior_alpha_q;
          alpha_q[1] <= prior_alpha_q;
          beta_q[0]  <= prior_beta_q;
          beta_q[1]  <= prior_beta_q;
        end
      end
      // write back the updated pair of the item's direction
      if (cmd_i.setup) begin
        alpha_q[item_q.direction] <= a_q;
        beta_q[item_q.direction]  <= b_q;
      end
      if (cmd_i.finish && low) lows_q <= lows_q + 1'b1;
    end
  end

  // Restoring divider, one quotient bit a cycle
  assign ge      = (rem_q >= {1'b0, sum_q});
  assign rem_sub = ge ? rem_q - {1'b0, sum_q} : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      sum_q <= {1'b0, a_q} + {1'b0, b_q};
      rem_q <= {2'b00, a_q};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_sub[32:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  // Posterior, zero when the precision is zero
  assign post_ext = (sum_q == '0) ? '0 : CW'(quo_q);
  assign low      = (item_q.operation == OP_OUTCOME) && (post_ext < thr_ext);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.posterior       <= post_ext[16:0];
      out_q.precision       <= sum_q;
      out_q.low_confidence  <= low;
      out_q.signal_count    <= signals_q;
      out_q.outcome_count   <= outcomes_q;
      out_q.low_event_count <= lows_q + {31'd0, low};
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_item_o           = out_q;
  assign status_o.outcome     = (item_q.operation == OP_OUTCOME);
  assign status_o.needs_decay = (forget_ext < ONE_CW);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

[sv/beta_posterior_tracker.sv]
// Steps after an input transfer: fetch; for an outcome, decay of alpha then beta when
// the forgetting factor is below 1.0, and the bump; then setup, divide and finish.
// A new item is taken only once the last result has entered the output register. The
// restoring divider yields one posterior bit a cycle; a result held back by an output
// stall keeps the block busy and so holds off the next input transfer.
// Reset: counts load 1.0 (65536) priors, event counters and output valid clear.
module beta_posterior_tracker
  import bpt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    busy;

  assign in_stall_o  = busy;
  assign cfg_ready_o = 1'b1;

  // Sequencer
  bpt_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Counts, decay, divider and output register
  bpt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
